FILE: hdl/sexpr_tok_pkg.sv
// Package for the s-expression tokenizer: beat types, lexer mode codes,
// event and error codes, and character class helpers.
// Depends on nothing; imported by sexpr_tokenizer, sexpr_tok_chk and the testbench.
`timescale 1ns / 1ps

package sexpr_tok_pkg;

  // Lexer modes, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_TOKEN  = 5'b00010,
    MODE_STRING = 5'b00100,
    MODE_ESCAPE = 5'b01000,
    MODE_FAILED = 5'b10000
  } lex_mode_t;

  typedef enum logic [2:0] {
    EV_OPEN  = 3'd0,
    EV_CLOSE = 3'd1,
    EV_CHAR  = 3'd2,
    EV_END   = 3'd3,
    EV_ERROR = 3'd4,
    EV_DONE  = 3'd5
  } ev_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_EXTRA_CLOSE = 3'd1,
    ERR_NL_IN_STR   = 3'd2,
    ERR_TRAIL_BSL   = 3'd3,
    ERR_OVERFLOW    = 3'd4,
    ERR_MISS_CLOSE  = 3'd5,
    ERR_UNFINISHED  = 3'd6,
    ERR_EARLIER     = 3'd7
  } err_code_t;

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] depth_out;
    logic       quoted;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  // Result of handling one byte from idle mode.
  typedef struct packed {
    lex_mode_t  mode;
    logic [7:0] depth;
    logic       esc;
    logic       ev_valid;
    out_item_t  ev;
  } idle_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_QUOTE);
  endfunction

  function automatic logic [7:0] decode(input logic [7:0] c);
    if (c == CH_N) return CH_LF;
    if (c == CH_T) return CH_TAB;
    return c;
  endfunction

  function automatic out_item_t mk_ev(input ev_kind_t k, input logic [7:0] ch,
                                      input logic [7:0] d, input logic q,
                                      input err_code_t e);
    out_item_t r;
    r.kind       = k;
    r.char_out   = ch;
    r.depth_out  = d;
    r.quoted     = q;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

FILE: hdl/sexpr_tokenizer.sv
// Top level of the s-expression tokenizer: lexer state, per-byte event
// logic and a two-slot result queue. Depends on sexpr_tok_pkg.
`timescale 1ns / 1ps

//  channel | signals                          | beat
//  --------+----------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data      | one byte or end of document
//  output  | out_valid, out_ready, out_data   | one event (0..2 per input beat)
//
// An input beat is lexed in the cycle it is accepted. One input beat per cycle
// is taken while each beat yields at most one event and the output is not
// stalled; a beat with two events holds the output port until both have left,
// and the two-slot event queue sets how far the input runs ahead.
// Reset (rst, synchronous) returns the lexer to idle at depth zero and empties
// the queue. A stalled output fills the queue and then drops in_ready.
module sexpr_tokenizer
  import sexpr_tok_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Depth ceiling: the depth field is eight bits wide.
  localparam int DEPTH_CAP = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
  localparam logic [7:0] DEPTH_LIM = DEPTH_CAP[7:0];

  // Lexer state.
  lex_mode_t  lex_mode, lex_mode_next;
  logic [7:0] nest_depth, nest_depth_next;
  logic       esc_pend, esc_pend_next;

  // Events of the current beat.
  out_item_t  ev0, ev1;
  logic [1:0] ev_cnt;

  // Result queue: head slot drives the port, tail slot absorbs one more beat.
  logic       hv, tv, hsel;
  out_item_t  h0, h1, t0, t1;

  // Handle a byte as idle mode would: brackets, string open, token start.
  function automatic idle_res_t idle_byte(input logic [7:0] c, input logic [7:0] d);
    idle_res_t r;
    r.mode     = MODE_IDLE;
    r.depth    = d;
    r.esc      = 1'b0;
    r.ev_valid = 1'b0;
    r.ev       = mk_ev(EV_OPEN, 8'h00, d, 1'b0, ERR_NONE);
    if (is_space(c)) begin
      r.ev_valid = 1'b0;
    end else if (c == CH_LPAREN) begin
      r.ev_valid = 1'b1;
      if (d >= DEPTH_LIM) begin
        r.mode = MODE_FAILED;
        r.ev   = mk_ev(EV_ERROR, 8'h00, d, 1'b0, ERR_OVERFLOW);
      end else begin
        r.depth = d + 8'd1;
        r.ev    = mk_ev(EV_OPEN, 8'h00, d + 8'd1, 1'b0, ERR_NONE);
      end
    end else if (c == CH_RPAREN) begin
      r.ev_valid = 1'b1;
      if (d == 8'd0) begin
        r.mode = MODE_FAILED;
        r.ev   = mk_ev(EV_ERROR, 8'h00, d, 1'b0, ERR_EXTRA_CLOSE);
      end else begin
        r.depth = d - 8'd1;
        r.ev    = mk_ev(EV_CLOSE, 8'h00, d - 8'd1, 1'b0, ERR_NONE);
      end
    end else if (c == CH_QUOTE) begin
      r.mode = MODE_STRING;
    end else if (c == CH_BSL) begin
      r.mode = MODE_TOKEN;
      r.esc  = 1'b1;
    end else begin
      r.mode     = MODE_TOKEN;
      r.ev_valid = 1'b1;
      r.ev       = mk_ev(EV_CHAR, c, d, 1'b0, ERR_NONE);
    end
    return r;
  endfunction

  // Per-beat lexing: next state plus up to two events.
  always_comb begin
    logic [7:0] c;
    logic       q;
    idle_res_t  ir;
    c  = in_data.byte_in;
    q  = (lex_mode == MODE_STRING) || (lex_mode == MODE_ESCAPE);
    ir = idle_byte(c, nest_depth);
    lex_mode_next   = lex_mode;
    nest_depth_next = nest_depth;
    esc_pend_next   = esc_pend;
    ev0    = mk_ev(EV_OPEN, 8'h00, nest_depth, 1'b0, ERR_NONE);
    ev1    = ev0;
    ev_cnt = 2'd0;
    if (in_data.func) begin
      // End of document: report, then return to reset state.
      ev_cnt = 2'd1;
      if (lex_mode == MODE_FAILED)
        ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, 1'b0, ERR_EARLIER);
      else if ((lex_mode == MODE_TOKEN) || q)
        ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, q, ERR_UNFINISHED);
      else if (nest_depth != 8'd0)
        ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, 1'b0, ERR_MISS_CLOSE);
      else
        ev0 = mk_ev(EV_DONE, 8'h00, nest_depth, 1'b0, ERR_NONE);
      lex_mode_next   = MODE_IDLE;
      nest_depth_next = 8'd0;
      esc_pend_next   = 1'b0;
    end else begin
      case (lex_mode)
        MODE_TOKEN: begin
          if (esc_pend) begin
            ev_cnt = 2'd1;
            if (is_space(c) || is_delim(c)) begin
              lex_mode_next = MODE_FAILED;
              esc_pend_next = 1'b0;
              ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, 1'b0, ERR_TRAIL_BSL);
            end else begin
              esc_pend_next = 1'b0;
              ev0 = mk_ev(EV_CHAR, decode(c), nest_depth, 1'b0, ERR_NONE);
            end
          end else if (is_space(c)) begin
            lex_mode_next = MODE_IDLE;
            ev_cnt = 2'd1;
            ev0 = mk_ev(EV_END, 8'h00, nest_depth, 1'b0, ERR_NONE);
          end else if (is_delim(c)) begin
            // End the atom, then handle the delimiter as a fresh byte.
            ev0 = mk_ev(EV_END, 8'h00, nest_depth, 1'b0, ERR_NONE);
            ev1 = ir.ev;
            ev_cnt = ir.ev_valid ? 2'd2 : 2'd1;
            lex_mode_next   = ir.mode;
            nest_depth_next = ir.depth;
            esc_pend_next   = ir.esc;
          end else if (c == CH_BSL) begin
            esc_pend_next = 1'b1;
          end else begin
            ev_cnt = 2'd1;
            ev0 = mk_ev(EV_CHAR, c, nest_depth, 1'b0, ERR_NONE);
          end
        end
        MODE_STRING: begin
          if ((c == CH_CR) || (c == CH_LF)) begin
            lex_mode_next = MODE_FAILED;
            esc_pend_next = 1'b0;
            ev_cnt = 2'd1;
            ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, 1'b1, ERR_NL_IN_STR);
          end else if (c == CH_QUOTE) begin
            lex_mode_next = MODE_IDLE;
            ev_cnt = 2'd1;
            ev0 = mk_ev(EV_END, 8'h00, nest_depth, 1'b1, ERR_NONE);
          end else if (c == CH_BSL) begin
            lex_mode_next = MODE_ESCAPE;
          end else begin
            ev_cnt = 2'd1;
            ev0 = mk_ev(EV_CHAR, c, nest_depth, 1'b1, ERR_NONE);
          end
        end
        MODE_ESCAPE: begin
          ev_cnt = 2'd1;
          if ((c == CH_CR) || (c == CH_LF)) begin
            lex_mode_next = MODE_FAILED;
            esc_pend_next = 1'b0;
            ev0 = mk_ev(EV_ERROR, 8'h00, nest_depth, 1'b1, ERR_NL_IN_STR);
          end else begin
            lex_mode_next = MODE_STRING;
            ev0 = mk_ev(EV_CHAR, decode(c), nest_depth, 1'b1, ERR_NONE);
          end
        end
        MODE_FAILED: begin
          ev_cnt = 2'd0;
        end
        default: begin
          // Idle, and any stray mode code acts as idle.
          lex_mode_next   = ir.mode;
          nest_depth_next = ir.depth;
          esc_pend_next   = ir.esc;
          ev0    = ir.ev;
          ev_cnt = ir.ev_valid ? 2'd1 : 2'd0;
        end
      endcase
    end
    // Flag the final event of the beat.
    if (ev_cnt == 2'd2) ev1.last = 1'b1;
    else                ev0.last = 1'b1;
  end

  logic      in_fire, push, head_free;
  out_item_t cur;

  assign in_ready  = !tv;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && (ev_cnt != 2'd0);
  assign cur       = hsel ? h1 : h0;
  assign out_valid = hv;
  assign out_data  = cur;
  // Head slot frees when empty or when its final event leaves.
  assign head_free = !hv || (out_ready && cur.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode   <= MODE_IDLE;
      nest_depth <= 8'd0;
      esc_pend   <= 1'b0;
      hv         <= 1'b0;
      tv         <= 1'b0;
      hsel       <= 1'b0;
    end else begin
      if (in_fire) begin
        lex_mode   <= lex_mode_next;
        nest_depth <= nest_depth_next;
        esc_pend   <= esc_pend_next;
      end
      if (head_free) begin
        hsel <= 1'b0;
        if (tv) begin
          // Advance the tail into the head; in_ready is low, so no push.
          hv <= 1'b1;
          h0 <= t0;
          h1 <= t1;
          tv <= 1'b0;
        end else if (push) begin
          hv <= 1'b1;
          h0 <= ev0;
          h1 <= ev1;
        end else begin
          hv <= 1'b0;
        end
      end else begin
        if (out_ready) hsel <= 1'b1;
        if (push) begin
          tv <= 1'b1;
          t0 <= ev0;
          t1 <= ev1;
        end
      end
    end
  end

endmodule

FILE: hdl/sexpr_tok_chk.sv
// Port checker for sexpr_tokenizer, with the bind that attaches it.
// Depends on sexpr_tok_pkg.
`timescale 1ns / 1ps

module sexpr_tok_chk
  import sexpr_tok_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting input beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // A stalled event beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Only error events carry an error code.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != EV_ERROR) |-> out_data.error_code == ERR_NONE)
    else $error("error code on a non-error event");

  // Done is reported only at depth zero outside a string, and ends its beat.
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == EV_DONE) |->
      (out_data.depth_out == 8'd0) && !out_data.quoted && out_data.last)
    else $error("done event with open depth or string");

  // An open event always leaves a nonzero depth.
  a_open_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == EV_OPEN) |-> out_data.depth_out != 8'd0)
    else $error("open event at depth zero");

endmodule

bind sexpr_tokenizer sexpr_tok_chk u_sexpr_tok_chk (.*);

FILE: test/testbench.sv
// Self-checking bench for sexpr_tokenizer: directed beats, a deep nesting run
// and random documents, all checked event by event. Depends on sexpr_tok_pkg.
`timescale 1ns / 1ps

module testbench;
  import sexpr_tok_pkg::*;

  localparam int MAX_NEST  = 255;
  localparam int NEST_CAP  = (MAX_NEST < 255) ? MAX_NEST : 255;
  localparam int RANDOM_BEATS = 320;
  localparam int QUIET_TAIL   = 100;   // last random beats run with no idling
  localparam int DRAIN_CYCLES = 16;
  localparam logic FN_BYTE = 1'b0;
  localparam logic FN_END  = 1'b1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;

  sexpr_tokenizer #(.MAX_DEPTH(MAX_NEST)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lexer state as the bench sees it, advanced once per accepted beat.
  lex_mode_t  tok_mode  = MODE_IDLE;
  logic [7:0] tok_depth = '0;
  logic       tok_esc   = 1'b0;

  out_item_t beat_events[$];   // events of the beat being lexed
  out_item_t events_due[$];    // events still owed by the block, oldest first

  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t  dir_rows[$];
  in_item_t  doc_beats[$];

  logic idle_on = 1'b0;
  int   rx_hold = 0;
  int   mismatches = 0;
  int   events_checked = 0;
  int   beats_sent = 0;
  int   docs_sent = 0;

  // ---------------------------------------------------------------------------
  // Character classes and escape decoding
  // ---------------------------------------------------------------------------
  function automatic logic white_byte(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default:                        return 1'b0;
    endcase
  endfunction

  function automatic logic punct_byte(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_QUOTE: return 1'b1;
      default:                        return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      CH_N:    return CH_LF;
      CH_T:    return CH_TAB;
      default: return c;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------
  task automatic add_event(input ev_kind_t k, input logic [7:0] ch, input logic q,
                           input err_code_t e);
    out_item_t ev;
    ev.kind       = k;
    ev.char_out   = ch;
    ev.depth_out  = tok_depth;
    ev.quoted     = q;
    ev.error_code = e;
    ev.last       = 1'b0;
    beat_events.push_back(ev);
  endtask

  task automatic go_failed(input err_code_t e, input logic q);
    tok_mode = MODE_FAILED;
    tok_esc  = 1'b0;
    add_event(EV_ERROR, 8'h00, q, e);
  endtask

  // A byte seen with no atom open.
  task automatic idle_byte(input logic [7:0] c);
    if (white_byte(c)) begin
      // separators give nothing
    end else if (c == CH_LPAREN) begin
      if (tok_depth >= NEST_CAP) begin
        go_failed(ERR_OVERFLOW, 1'b0);
      end else begin
        tok_depth = tok_depth + 8'd1;
        add_event(EV_OPEN, 8'h00, 1'b0, ERR_NONE);
      end
    end else if (c == CH_RPAREN) begin
      if (tok_depth == 0) begin
        go_failed(ERR_EXTRA_CLOSE, 1'b0);
      end else begin
        tok_depth = tok_depth - 8'd1;
        add_event(EV_CLOSE, 8'h00, 1'b0, ERR_NONE);
      end
    end else if (c == CH_QUOTE) begin
      tok_mode = MODE_STRING;
    end else if (c == CH_BSL) begin
      tok_mode = MODE_TOKEN;
      tok_esc  = 1'b1;
    end else begin
      tok_mode = MODE_TOKEN;
      add_event(EV_CHAR, c, 1'b0, ERR_NONE);
    end
  endtask

  // Lex one beat: fill beat_events and flag the final one.
  task automatic lex_beat(input in_item_t b);
    logic [7:0] c;
    logic       in_str;
    out_item_t  tail;
    beat_events.delete();
    c = b.byte_in;
    if (b.func == FN_END) begin
      in_str = (tok_mode == MODE_STRING) || (tok_mode == MODE_ESCAPE);
      if (tok_mode == MODE_FAILED)
        add_event(EV_ERROR, 8'h00, 1'b0, ERR_EARLIER);
      else if (tok_mode == MODE_TOKEN || in_str)
        add_event(EV_ERROR, 8'h00, in_str, ERR_UNFINISHED);
      else if (tok_depth != 0)
        add_event(EV_ERROR, 8'h00, 1'b0, ERR_MISS_CLOSE);
      else
        add_event(EV_DONE, 8'h00, 1'b0, ERR_NONE);
      tok_mode  = MODE_IDLE;
      tok_depth = '0;
      tok_esc   = 1'b0;
    end else begin
      case (tok_mode)
        MODE_TOKEN: begin
          if (tok_esc) begin
            if (white_byte(c) || punct_byte(c)) begin
              go_failed(ERR_TRAIL_BSL, 1'b0);
            end else begin
              tok_esc = 1'b0;
              add_event(EV_CHAR, unescape(c), 1'b0, ERR_NONE);
            end
          end else if (white_byte(c)) begin
            tok_mode = MODE_IDLE;
            add_event(EV_END, 8'h00, 1'b0, ERR_NONE);
          end else if (punct_byte(c)) begin
            // close the token, then handle the delimiter afresh
            tok_mode = MODE_IDLE;
            add_event(EV_END, 8'h00, 1'b0, ERR_NONE);
            idle_byte(c);
          end else if (c == CH_BSL) begin
            tok_esc = 1'b1;
          end else begin
            add_event(EV_CHAR, c, 1'b0, ERR_NONE);
          end
        end
        MODE_STRING: begin
          if (c == CH_CR || c == CH_LF) begin
            go_failed(ERR_NL_IN_STR, 1'b1);
          end else if (c == CH_QUOTE) begin
            tok_mode = MODE_IDLE;
            add_event(EV_END, 8'h00, 1'b1, ERR_NONE);
          end else if (c == CH_BSL) begin
            tok_mode = MODE_ESCAPE;
          end else begin
            add_event(EV_CHAR, c, 1'b1, ERR_NONE);
          end
        end
        MODE_ESCAPE: begin
          if (c == CH_CR || c == CH_LF) begin
            go_failed(ERR_NL_IN_STR, 1'b1);
          end else begin
            tok_mode = MODE_STRING;
            add_event(EV_CHAR, unescape(c), 1'b1, ERR_NONE);
          end
        end
        MODE_FAILED: begin
          // drop bytes until end of document
        end
        default: begin
          tok_mode = MODE_IDLE;
          idle_byte(c);
        end
      endcase
    end
    if (beat_events.size() != 0) begin
      tail      = beat_events.pop_back();
      tail.last = 1'b1;
      beat_events.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: optional idle burst, then hold the beat until it is taken.
  // A typed beat owes the hand-written event instead of the predicted ones.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input in_item_t b, input logic typed, input out_item_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    lex_beat(b);
    if (typed) begin
      events_due.push_back(want);
    end else begin
      foreach (beat_events[i]) events_due.push_back(beat_events[i]);
    end
    beats_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  task automatic row(input logic f, input logic [7:0] c);
    dir_row_t r;
    r = '0;
    r.beat.func    = f;
    r.beat.byte_in = (f == FN_END) ? 8'($urandom) : c;
    dir_rows.push_back(r);
  endtask

  task automatic row_typed(input logic f, input logic [7:0] c, input ev_kind_t k,
                           input logic [7:0] d, input logic q, input err_code_t e);
    dir_row_t r;
    r = '0;
    r.beat.func       = f;
    r.beat.byte_in    = (f == FN_END) ? 8'($urandom) : c;
    r.typed           = 1'b1;
    r.want.kind       = k;
    r.want.depth_out  = d;
    r.want.quoted     = q;
    r.want.error_code = e;
    r.want.last       = 1'b1;
    dir_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Random document builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_bare();
    logic [7:0] c;
    do c = 8'($urandom); while (white_byte(c) || punct_byte(c) || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] pick_str();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_CR || c == CH_LF || c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] pick_white();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Byte after a backslash; favor the two decoded letters.
  function automatic logic [7:0] pick_escaped(input logic in_string);
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: return CH_N;
      1: return CH_T;
      default: begin
        if (in_string)
          do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
        else
          do c = 8'($urandom); while (white_byte(c) || punct_byte(c));
        return c;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] c);
    in_item_t b;
    b.func    = FN_BYTE;
    b.byte_in = c;
    doc_beats.push_back(b);
  endtask

  // Mostly well-formed documents with random content; now and then a stray
  // byte, a bad escape, a newline in a string or a missing close.
  task automatic build_document();
    int depth, limit, n_elem, len, pick;
    in_item_t b;
    doc_beats.delete();
    depth  = 0;
    limit  = $urandom_range(1, 6);
    n_elem = $urandom_range(3, 14);
    for (int i = 0; i < n_elem; i++) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) begin
        push_byte(8'($urandom));
      end else if (pick < 2 && depth < limit) begin
        push_byte(CH_LPAREN);
        depth++;
      end else if (pick < 4 && depth > 0) begin
        push_byte(CH_RPAREN);
        depth--;
      end else if (pick < 7) begin
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 5) == 0) begin
            push_byte(CH_BSL);
            push_byte(pick_escaped(1'b0));
          end else begin
            push_byte(pick_bare());
          end
        end
        if ($urandom_range(0, 19) == 0) push_byte(CH_BSL);
        if ($urandom_range(0, 1) == 0) push_byte(pick_white());
      end else begin
        push_byte(CH_QUOTE);
        len = $urandom_range(0, 5);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 29) == 0) begin
            push_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
          end else if ($urandom_range(0, 4) == 0) begin
            push_byte(CH_BSL);
            push_byte(pick_escaped(1'b1));
          end else begin
            push_byte(pick_str());
          end
        end
        push_byte(CH_QUOTE);
      end
      if ($urandom_range(0, 2) == 0) push_byte(pick_white());
    end
    if ($urandom_range(0, 9) != 0) begin
      repeat (depth) push_byte(CH_RPAREN);
    end
    b.func    = FN_END;
    b.byte_in = 8'($urandom);
    doc_beats.push_back(b);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts on out_ready while idling is on.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold != 0)
      rx_hold = rx_hold - 1;
    else if (idle_on && $urandom_range(0, 4) == 0)
      rx_hold = $urandom_range(1, 3);
    out_ready <= (rx_hold == 0);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH t=%0t event %0d: %s got %0d want %0d",
               $time, events_checked, what, got, want);
  endtask

  // Compare every accepted event with the oldest one owed.
  always @(posedge clk) begin : check_events
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        report_mismatch("unexpected event, kind", out_data.kind, 0);
      end else begin
        want = events_due.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.char_out !== want.char_out)
          report_mismatch("char_out", out_data.char_out, want.char_out);
        if (out_data.depth_out !== want.depth_out)
          report_mismatch("depth_out", out_data.depth_out, want.depth_out);
        if (out_data.quoted !== want.quoted)
          report_mismatch("quoted", out_data.quoted, want.quoted);
        if (out_data.error_code !== want.error_code)
          report_mismatch("error_code", out_data.error_code, want.error_code);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
      events_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    out_item_t no_event;
    in_item_t  b;
    int        dir_count, deep_count, random_count;
    no_event = '0;

    repeat (4) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;

    // Directed rows: clean finish, extra close, failed mode, escapes, empty
    // string, extreme bytes, newline in string, dangling backslash, missing
    // close and an unfinished string at end of document.
    row_typed(FN_END, 8'h00, EV_DONE, 8'd0, 1'b0, ERR_NONE);
    row_typed(FN_BYTE, CH_RPAREN, EV_ERROR, 8'd0, 1'b0, ERR_EXTRA_CLOSE);
    row_typed(FN_END, 8'h00, EV_ERROR, 8'd0, 1'b0, ERR_EARLIER);
    row(FN_BYTE, CH_LPAREN);
    row(FN_BYTE, 8'h00);                 // zero byte starts a token
    row(FN_BYTE, CH_BSL);
    row(FN_BYTE, CH_N);
    row(FN_BYTE, 8'h71);                 // 'q'
    row(FN_BYTE, CH_QUOTE);              // ends the token, opens a string
    row(FN_BYTE, CH_QUOTE);              // empty string
    row(FN_BYTE, CH_QUOTE);
    row(FN_BYTE, CH_BSL);
    row(FN_BYTE, CH_T);
    row(FN_BYTE, 8'hFF);
    row_typed(FN_BYTE, CH_LF, EV_ERROR, 8'd1, 1'b1, ERR_NL_IN_STR);
    row_typed(FN_END, 8'h00, EV_ERROR, 8'd1, 1'b0, ERR_EARLIER);
    row(FN_BYTE, CH_BSL);
    row_typed(FN_BYTE, CH_SPACE, EV_ERROR, 8'd0, 1'b0, ERR_TRAIL_BSL);
    row_typed(FN_END, 8'h00, EV_ERROR, 8'd0, 1'b0, ERR_EARLIER);
    row(FN_BYTE, CH_LPAREN);
    row(FN_BYTE, 8'h6B);                 // 'k'
    row(FN_BYTE, CH_RPAREN);             // atom end, then close
    row(FN_BYTE, CH_LPAREN);
    row_typed(FN_END, 8'h00, EV_ERROR, 8'd1, 1'b0, ERR_MISS_CLOSE);
    row(FN_BYTE, CH_QUOTE);
    row_typed(FN_END, 8'h00, EV_ERROR, 8'd0, 1'b1, ERR_UNFINISHED);
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    dir_count = beats_sent;

    // Nest to the cap, push one level past it, then end the document.
    b.func    = FN_BYTE;
    b.byte_in = CH_LPAREN;
    repeat (NEST_CAP) send_beat(b, 1'b0, no_event);
    send_beat(b, 1'b1, '{kind: EV_ERROR, char_out: 8'h00, depth_out: 8'(NEST_CAP),
                         quoted: 1'b0, error_code: ERR_OVERFLOW, last: 1'b1});
    b.func    = FN_END;
    b.byte_in = 8'($urandom);
    send_beat(b, 1'b0, no_event);
    deep_count = beats_sent - dir_count;

    // Random documents; idling switches on and off per document and stays
    // off for the tail of the run.
    while (beats_sent - dir_count - deep_count < RANDOM_BEATS) begin
      idle_on <= ($urandom_range(0, 3) != 0) &&
                 (beats_sent - dir_count - deep_count < RANDOM_BEATS - QUIET_TAIL);
      build_document();
      foreach (doc_beats[i]) send_beat(doc_beats[i], 1'b0, no_event);
      docs_sent++;
    end
    random_count = beats_sent - dir_count - deep_count;
    in_valid <= 1'b0;
    idle_on  <= 1'b0;

    // Drain owed events, then give the block time to show anything extra.
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d beats: %0d directed, %0d nesting to depth %0d,",
             beats_sent, dir_count, deep_count, NEST_CAP);
    $display("  %0d random in %0d documents; checked %0d events, %0d mismatches",
             random_count, docs_sent, events_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
